>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the box blur RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// A condition that must hold at every clock edge out of reset.
`define BB_ASSERT(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("box blur invariant violated");

// A condition that must hold in the same cycle as a trigger.
`define BB_ASSERT_IMP(lbl, clk, rst_n, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("box blur same-cycle implication violated");

// A condition that must hold in the cycle after a trigger.
`define BB_ASSERT_NEXT(lbl, clk, rst_n, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("box blur next-cycle implication violated");

`else

`define BB_ASSERT(lbl, clk, rst_n, cond)
`define BB_ASSERT_IMP(lbl, clk, rst_n, trig, cond)
`define BB_ASSERT_NEXT(lbl, clk, rst_n, trig, cond)

`endif

`endif

>>> hw/rtl/boxblur_pkg.sv
// Shared constants, types and helper functions for the 3x3 box blur.
package boxblur_pkg;

    // Frame limits and the widths that follow from them.
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 4096;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int WID_W      = $clog2(MAX_WIDTH + 1);
    localparam int HGT_W      = $clog2(MAX_HEIGHT + 1);
    // The input row runs up to two rows past the frame while it drains.
    localparam int IN_ROW_W   = $clog2(MAX_HEIGHT + 3);

    // Configuration port.
    localparam int CFG_WIDTH_W  = 12;
    localparam int CFG_HEIGHT_W = 13;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_INDEX_W  = 1;
    localparam logic [CFG_WIDTH_W-1:0]  RESET_WIDTH  = CFG_WIDTH_W'(640);
    localparam logic [CFG_HEIGHT_W-1:0] RESET_HEIGHT = CFG_HEIGHT_W'(480);

    // Pixel and arithmetic widths.
    localparam int CH_W   = 8;
    localparam int PIX_W  = 3 * CH_W;
    localparam int SUM_W  = 12;
    localparam int NCNT_W = 4;

    // Division by the neighbor count as a multiply by a rounded-up reciprocal.
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int PROD_W      = SUM_W + RECIP_W;
    localparam int RECIP_1     = (1 << RECIP_SHIFT);
    localparam int RECIP_2     = ((1 << RECIP_SHIFT) + 1) / 2;
    localparam int RECIP_3     = ((1 << RECIP_SHIFT) + 2) / 3;
    localparam int RECIP_4     = ((1 << RECIP_SHIFT) + 3) / 4;
    localparam int RECIP_6     = ((1 << RECIP_SHIFT) + 5) / 6;
    localparam int RECIP_9     = ((1 << RECIP_SHIFT) + 8) / 9;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        MODE_PIXEL = 1'b0,
        MODE_FLUSH = 1'b1
    } item_mode_t;

    // Payload of one input beat.
    typedef struct packed {
        logic            mode;
        logic [CH_W-1:0] in_red;
        logic [CH_W-1:0] in_green;
        logic [CH_W-1:0] in_blue;
    } pix_in_t;

    // Payload of one result beat.
    typedef struct packed {
        logic [CH_W-1:0] out_red;
        logic [CH_W-1:0] out_green;
        logic [CH_W-1:0] out_blue;
        logic            frame_end;
    } blur_out_t;

    // Packed pixel: red in the low byte, blue in the high byte.
    typedef logic [PIX_W-1:0] rgb_t;

    // Which sides of the neighborhood lie inside the image.
    typedef struct packed {
        logic top;
        logic bottom;
        logic left;
        logic right;
        logic last;
    } border_t;

    // Per-beat control handed from the counters to the line buffer.
    typedef struct packed {
        logic             produce;
        logic [COL_W-1:0] addr;
        border_t          border;
    } slot_t;

    // Handshake and control from the line buffer into the window.
    typedef struct packed {
        logic    fire;
        logic    produce;
        border_t border;
    } shift_t;

    // New right-hand column of the window.
    typedef struct packed {
        rgb_t up;
        rgb_t mid;
        rgb_t low;
    } column_t;

    // Rounded-up channel sums and neighbor count.
    typedef struct packed {
        logic [SUM_W-1:0]  red;
        logic [SUM_W-1:0]  green;
        logic [SUM_W-1:0]  blue;
        logic [NCNT_W-1:0] count;
        logic              last;
    } sums_t;

    // Effective frame width: zero acts as one, oversize is capped.
    function automatic logic [WID_W-1:0] clamp_width(input logic [CFG_WIDTH_W-1:0] value);
        logic [WID_W-1:0] result;
        if (value == '0)
            result = WID_W'(1);
        else if (int'(value) > MAX_WIDTH)
            result = WID_W'(MAX_WIDTH);
        else
            result = WID_W'(value);
        return result;
    endfunction

    // Effective frame height: zero acts as one, oversize is capped.
    function automatic logic [HGT_W-1:0] clamp_height(input logic [CFG_HEIGHT_W-1:0] value);
        logic [HGT_W-1:0] result;
        if (value == '0)
            result = HGT_W'(1);
        else if (int'(value) > MAX_HEIGHT)
            result = HGT_W'(MAX_HEIGHT);
        else
            result = HGT_W'(value);
        return result;
    endfunction

    // Reciprocal multiplier for each possible neighbor count.
    function automatic logic [RECIP_W-1:0] recip(input logic [NCNT_W-1:0] count);
        logic [RECIP_W-1:0] m;
        case (count)
            NCNT_W'(1): m = RECIP_W'(RECIP_1);
            NCNT_W'(2): m = RECIP_W'(RECIP_2);
            NCNT_W'(3): m = RECIP_W'(RECIP_3);
            NCNT_W'(4): m = RECIP_W'(RECIP_4);
            NCNT_W'(6): m = RECIP_W'(RECIP_6);
            NCNT_W'(9): m = RECIP_W'(RECIP_9);
            default:    m = '0;
        endcase
        return m;
    endfunction

endpackage

>>> hw/rtl/box_blur_3x3_clipped.sv
// Top level of the streaming 3x3 box blur with the neighborhood clipped to the image.
//
// Channel | Dir | Handshake              | Payload
// cfg     | in  | cfg_write              | cfg_index, cfg_data
// pix     | in  | pix_valid, pix_stall   | boxblur_pkg::pix_in_t
// blur    | out | blur_valid, blur_stall | boxblur_pkg::blur_out_t
//
// One beat is taken every cycle while pix_stall is low; the line memory does one read
// and one write per cycle. The result for pixel k is carried by the beat after pixel
// k + width and is registered through the line buffer, window, sums and result stages.
// Reset clears the counters and stage valids; the line memory has no clearing pass.
// blur_stall backs up through the four stages; pix_stall rises only once all are full.
`include "assert_macros.svh"

module box_blur_3x3_clipped (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [boxblur_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [boxblur_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                                pix_valid,
    output logic                                pix_stall,
    input  boxblur_pkg::pix_in_t                pix_data,
    output logic                                blur_valid,
    input  logic                                blur_stall,
    output boxblur_pkg::blur_out_t              blur_data
);
    import boxblur_pkg::*;

    logic    take;
    logic    keep;
    logic    pad;
    logic    load;
    logic    lb_ready;
    logic    win_ready;
    logic    div_ready;
    logic    sums_valid;
    rgb_t    px_in;
    slot_t   slot;
    shift_t  shift;
    column_t column;
    sums_t   sums;

    // Input beat acceptance; drained frames feed zero pixels.
    assign take      = pix_valid && !pix_stall;
    assign load      = take && keep;
    assign pix_stall = !lb_ready;
    assign px_in     = pad ? '0 : {pix_data.in_blue, pix_data.in_green, pix_data.in_red};

    boxblur_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .take      (take),
        .flush_req (pix_data.mode == MODE_FLUSH),
        .keep      (keep),
        .pad       (pad),
        .slot      (slot)
    );

    boxblur_line_buf u_line_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (load),
        .px_in      (px_in),
        .slot       (slot),
        .down_ready (win_ready),
        .ready      (lb_ready),
        .shift      (shift),
        .column     (column)
    );

    boxblur_window u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .shift      (shift),
        .column     (column),
        .down_ready (div_ready),
        .ready      (win_ready),
        .sums_valid (sums_valid),
        .sums       (sums)
    );

    boxblur_divide u_divide (
        .clk        (clk),
        .rst_n      (rst_n),
        .sums_valid (sums_valid),
        .sums       (sums),
        .blur_stall (blur_stall),
        .ready      (div_ready),
        .blur_valid (blur_valid),
        .blur_data  (blur_data)
    );

    // Input backpressure only when a result is waiting and held off downstream.
    `BB_ASSERT_IMP(a_stall_needs_full, clk, rst_n, pix_stall, blur_valid && blur_stall)

endmodule

>>> hw/rtl/boxblur_ctrl.sv
// Frame configuration registers and the input and output position counters.
`include "assert_macros.svh"

module boxblur_ctrl (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [boxblur_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [boxblur_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                                take,
    input  logic                                flush_req,
    output logic                                keep,
    output logic                                pad,
    output boxblur_pkg::slot_t                  slot
);
    import boxblur_pkg::*;

    logic [WID_W-1:0]    width_reg, width_next;
    logic [HGT_W-1:0]    height_reg, height_next;
    logic [COL_W-1:0]    in_col_reg, in_col_next;
    logic [IN_ROW_W-1:0] in_row_reg, in_row_next;
    logic [COL_W-1:0]    out_col_reg, out_col_next;
    logic [ROW_W-1:0]    out_row_reg, out_row_next;

    logic    input_done;
    logic    produce;
    logic    in_col_end;
    logic    out_col_end;
    logic    out_row_end;
    border_t border;

    // Position decode for the beat that is offered now.
    always_comb
    begin
        input_done  = in_row_reg >= IN_ROW_W'(height_reg);
        produce     = (in_row_reg > IN_ROW_W'(1))
                    || ((in_row_reg == IN_ROW_W'(1)) && (in_col_reg != '0));
        in_col_end  = (WID_W'(in_col_reg) + WID_W'(1)) >= width_reg;
        out_col_end = (WID_W'(out_col_reg) + WID_W'(1)) >= width_reg;
        out_row_end = (HGT_W'(out_row_reg) + HGT_W'(1)) >= height_reg;

        border.top    = out_row_reg != '0;
        border.bottom = !out_row_end;
        border.left   = out_col_reg != '0;
        border.right  = !out_col_end;
        border.last   = out_row_end && out_col_end;

        // A flush before the frame is complete is dropped; after it, pixels act as flushes.
        keep = !(flush_req && !input_done);
        pad  = input_done;

        slot.produce = produce;
        slot.addr    = in_col_reg;
        slot.border  = border;
    end

    // Configuration writes and counter advance.
    always_comb
    begin
        width_next   = width_reg;
        height_next  = height_reg;
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;

        if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_FRAME_WIDTH:  width_next  = clamp_width(cfg_data[CFG_WIDTH_W-1:0]);
                REG_FRAME_HEIGHT: height_next = clamp_height(cfg_data[CFG_HEIGHT_W-1:0]);
                default: ;
            endcase
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
        else if (take && keep)
        begin
            if (in_col_end)
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + IN_ROW_W'(1);
            end
            else
            begin
                in_col_next = in_col_reg + COL_W'(1);
            end

            if (produce)
            begin
                if (border.last)
                begin
                    // Frame done: the next pixel starts a new frame.
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                end
                else if (out_col_end)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + ROW_W'(1);
                end
                else
                begin
                    out_col_next = out_col_reg + COL_W'(1);
                end
            end
        end
    end

    // Registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= clamp_width(RESET_WIDTH);
            height_reg  <= clamp_height(RESET_HEIGHT);
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else
        begin
            width_reg   <= width_next;
            height_reg  <= height_next;
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    // The input column always addresses a stored entry inside the row.
    `BB_ASSERT(a_col_in_row, clk, rst_n, WID_W'(in_col_reg) < width_reg)
    // The beat that carries the frame's last result restarts all counters.
    `BB_ASSERT_NEXT(a_frame_restart, clk, rst_n, take && keep && produce && border.last && !cfg_write, in_col_reg == '0 && in_row_reg == '0 && out_col_reg == '0 && out_row_reg == '0)

endmodule

>>> hw/rtl/boxblur_line_buf.sv
// Two-row line memory with its read stage and same-address forwarding.
`include "assert_macros.svh"

module boxblur_line_buf (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  boxblur_pkg::rgb_t    px_in,
    input  boxblur_pkg::slot_t   slot,
    input  logic                 down_ready,
    output logic                 ready,
    output boxblur_pkg::shift_t  shift,
    output boxblur_pkg::column_t column
);
    import boxblur_pkg::*;

    // Each entry holds the upper row in the high half and the lower row in the low half.
    logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];

    logic               valid_reg;
    rgb_t               px_reg;
    slot_t              slot_reg;
    logic [2*PIX_W-1:0] rd_reg;
    logic               hit_reg;
    logic [2*PIX_W-1:0] fwd_reg;

    logic               fire;
    logic               hit_next;
    logic [2*PIX_W-1:0] pair;
    logic [2*PIX_W-1:0] wr_pair;

    // Stage handshake and the column leaving this stage.
    always_comb
    begin
        fire     = valid_reg && down_ready;
        ready    = !valid_reg || down_ready;
        // A read at the address being written this edge sees stale data; take the write.
        hit_next = fire && (slot_reg.addr == slot.addr);
        pair     = hit_reg ? fwd_reg : rd_reg;
        wr_pair  = {pair[PIX_W-1:0], px_reg};

        column.up  = pair[2*PIX_W-1:PIX_W];
        column.mid = pair[PIX_W-1:0];
        column.low = px_reg;

        shift.fire    = fire;
        shift.produce = slot_reg.produce;
        shift.border  = slot_reg.border;
    end

    // Line memory: the lower row moves up and the new pixel becomes the lower row.
    always_ff @(posedge clk)
    begin
        if (fire)
            line_mem[slot_reg.addr] <= wr_pair;
        if (load)
            rd_reg <= line_mem[slot.addr];
    end

    // Stage payload.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            px_reg   <= px_in;
            slot_reg <= slot;
            hit_reg  <= hit_next;
            fwd_reg  <= wr_pair;
        end
    end

    // Stage occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (ready)
            valid_reg <= load;
    end

    // A beat is loaded only when this stage can take it.
    `BB_ASSERT_IMP(a_load_when_ready, clk, rst_n, load, ready)

endmodule

>>> hw/rtl/boxblur_window.sv
// 3x3 pixel window and the clipped neighborhood sum stage.
`include "assert_macros.svh"

module boxblur_window (
    input  logic                 clk,
    input  logic                 rst_n,
    input  boxblur_pkg::shift_t  shift,
    input  boxblur_pkg::column_t column,
    input  logic                 down_ready,
    output logic                 ready,
    output logic                 sums_valid,
    output boxblur_pkg::sums_t   sums
);
    import boxblur_pkg::*;

    // Rows: above, center, below. Columns: left, center, right.
    rgb_t    win_reg [3][3];
    border_t border_reg;
    logic    s2_valid_reg;
    logic    s3_valid_reg;
    sums_t   sums_reg;

    logic              s3_ready;
    logic              s2_fire;
    logic [2:0]        row_use;
    logic [2:0]        col_use;
    logic [1:0]        rows;
    logic [1:0]        cols;
    logic [NCNT_W-1:0] count;
    logic [NCNT_W-1:0] half;
    logic [SUM_W-1:0]  row_sum [3][3];
    logic [SUM_W-1:0]  total [3];
    sums_t             sums_next;

    assign s3_ready   = !s3_valid_reg || down_ready;
    assign ready      = !s2_valid_reg || s3_ready;
    assign s2_fire    = s2_valid_reg && s3_ready;
    assign sums_valid = s3_valid_reg;
    assign sums       = sums_reg;

    // Masked sums over the part of the window that lies inside the image.
    always_comb
    begin
        row_use = {border_reg.bottom, 1'b1, border_reg.top};
        col_use = {border_reg.right, 1'b1, border_reg.left};
        rows    = 2'd1 + 2'(border_reg.top) + 2'(border_reg.bottom);
        cols    = 2'd1 + 2'(border_reg.left) + 2'(border_reg.right);
        count   = NCNT_W'(rows) * NCNT_W'(cols);
        half    = count >> 1;

        for (int ch = 0; ch < 3; ch++)
        begin
            for (int r = 0; r < 3; r++)
            begin
                row_sum[ch][r] = '0;
                for (int k = 0; k < 3; k++)
                begin
                    if (row_use[r] && col_use[k])
                        row_sum[ch][r] = row_sum[ch][r]
                                       + SUM_W'(win_reg[r][k][ch*CH_W +: CH_W]);
                end
            end
            total[ch] = row_sum[ch][0] + row_sum[ch][1] + row_sum[ch][2] + SUM_W'(half);
        end

        sums_next.red   = total[0];
        sums_next.green = total[1];
        sums_next.blue  = total[2];
        sums_next.count = count;
        sums_next.last  = border_reg.last;
    end

    // Window shift and sum register.
    always_ff @(posedge clk)
    begin
        if (shift.fire)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_reg[r][0] <= win_reg[r][1];
                win_reg[r][1] <= win_reg[r][2];
            end
            win_reg[0][2] <= column.up;
            win_reg[1][2] <= column.mid;
            win_reg[2][2] <= column.low;
            border_reg    <= shift.border;
        end
        if (s2_fire)
            sums_reg <= sums_next;
    end

    // Stage occupancy: only beats that yield a result occupy the window stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (ready)
                s2_valid_reg <= shift.fire && shift.produce;
            if (s3_ready)
                s3_valid_reg <= s2_valid_reg;
        end
    end

    // The neighbor count is always a product of one to three rows and columns.
    `BB_ASSERT_IMP(a_count_legal, clk, rst_n, sums_valid, sums.count == NCNT_W'(1) || sums.count == NCNT_W'(2) || sums.count == NCNT_W'(3) || sums.count == NCNT_W'(4) || sums.count == NCNT_W'(6) || sums.count == NCNT_W'(9))

endmodule

>>> hw/rtl/boxblur_divide.sv
// Division of the channel sums by the neighbor count and the result register.
module boxblur_divide (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   sums_valid,
    input  boxblur_pkg::sums_t     sums,
    input  logic                   blur_stall,
    output logic                   ready,
    output logic                   blur_valid,
    output boxblur_pkg::blur_out_t blur_data
);
    import boxblur_pkg::*;

    logic      valid_reg;
    blur_out_t data_reg;

    logic [RECIP_W-1:0] m;
    logic [PROD_W-1:0]  prod_red;
    logic [PROD_W-1:0]  prod_green;
    logic [PROD_W-1:0]  prod_blue;
    blur_out_t          result;

    assign ready      = !valid_reg || !blur_stall;
    assign blur_valid = valid_reg;
    assign blur_data  = data_reg;

    // Multiply by the reciprocal and keep the integer part.
    always_comb
    begin
        m          = recip(sums.count);
        prod_red   = PROD_W'(sums.red) * PROD_W'(m);
        prod_green = PROD_W'(sums.green) * PROD_W'(m);
        prod_blue  = PROD_W'(sums.blue) * PROD_W'(m);

        result.out_red   = prod_red[RECIP_SHIFT +: CH_W];
        result.out_green = prod_green[RECIP_SHIFT +: CH_W];
        result.out_blue  = prod_blue[RECIP_SHIFT +: CH_W];
        result.frame_end = sums.last;
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (ready && sums_valid)
            data_reg <= result;
    end

    // Result occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (ready)
            valid_reg <= sums_valid;
    end

endmodule
